FILE: rtl/core/kalman_filter_two_state_defines.svh
// Assertion macros shared by the filter modules.
`ifndef KALMAN_FILTER_TWO_STATE_DEFINES_SVH
`define KALMAN_FILTER_TWO_STATE_DEFINES_SVH
`define KF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define KF_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: rtl/core/kf2s_pkg.sv
`default_nettype none
package kf2s_pkg;
    localparam int CHANNELS      = 2;
    localparam int CH_W          = 1;
    localparam int FRACTION_BITS = 24;
    localparam int REG_W         = 25;
    localparam logic [REG_W-1:0] DT_RESET = 25'd536871;
    localparam logic [REG_W-1:0] Q_RESET  = 25'd1678;
    localparam logic [REG_W-1:0] R_RESET  = 25'd838861;
    localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRACTION_BITS;
    localparam logic [1:0] REG_DT = 2'd0;
    localparam logic [1:0] REG_Q  = 2'd1;
    localparam logic [1:0] REG_R  = 2'd2;
    // Divider quotient bits: magnitude < 2^31 shifted up by the fraction.
    localparam int DIV_BITS = 31 + FRACTION_BITS + 1;

    function automatic logic signed [31:0] clip32(input logic signed [65:0] v,
                                                   output logic f);
        f = 1'b0;
        if (v > 66'sh7FFFFFFF)
        begin
            f = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -66'sh80000000)
        begin
            f = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/kalman_filter_two_state.sv
// Two-state (distance, velocity) Kalman filter, one filter per channel.
// Input channel: valid/stall with fields channel and measurement (Q8.24).
// Output channel: valid/stall with distance_estimate, velocity_estimate and
// saturated. One result item per input item, in order.
// Config channel: cfg_valid/cfg_ready, cfg_index 0..2 selects the sample
// interval, process_noise, measurement_noise; other indexes are ignored.
// Write only while idle.
// An item runs through one shared 32x32 multiply-round-clip unit under a
// sequencer: 11 multiply steps and two serial divisions of 56 quotient bits,
// one bit per cycle. Both divisions are skipped when the innovation
// variance is not positive.
// The block takes no new item until its result has been accepted by the
// receiver; while out_stall is high the result holds.
// Reset sets registers to their defaults and every channel to distance 0,
// velocity 0 and unit diagonal covariance, at once.
`default_nettype none
`include "kalman_filter_two_state_defines.svh"
module kalman_filter_two_state (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               channel,
    input  wire logic signed [31:0] measurement,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      distance_estimate,
    output logic signed [31:0]      velocity_estimate,
    output logic                    saturated,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [24:0]        cfg_data
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_DIV0 = 7'b0000100,
        S_WAIT0 = 7'b0001000, S_DIV1 = 7'b0010000, S_WAIT1 = 7'b0100000,
        S_OUT = 7'b1000000
    } state_t;
    localparam int NCH = kf2s_pkg::CHANNELS;
    state_t state_reg;
    logic [24:0] dt_reg, q_reg, r_reg;
    logic signed [31:0] sd_reg [NCH], sv_reg [NCH], p00_reg [NCH], p01_reg [NCH];
    logic signed [31:0] p10_reg [NCH], p11_reg [NCH];
    logic [kf2s_pkg::CH_W-1:0] ch_reg;
    logic skip_reg, sat_reg;
    logic signed [31:0] z_reg, d_reg, v_reg, dp_reg, a_reg, b_reg, n00_reg, n10_reg;
    logic signed [31:0] n11_reg, y_reg, k0_reg, k1_reg, o00_reg, o01_reg, o10_reg;
    logic [3:0] step_reg;
    // Shared unit: clip(round(ma*mb)) then optionally clip(addend + or - product).
    // The n00 step also adds q inside that same clip.
    logic signed [31:0] ma, mb, madd, mres;
    logic msub, mf1, mf2;
    logic signed [63:0] prod;
    logic signed [65:0] rnd, acc;
    logic signed [31:0] pc;
    logic div_start, div_done, div_sat;
    logic signed [31:0] div_num, div_q;
    logic signed [33:0] s_val;
    logic signed [31:0] g_val, n11_q;
    logic g_f, n11_f, y_f;
    logic signed [31:0] y_val;

    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        ma = '0; mb = '0; madd = '0; msub = 1'b0;
        unique case (step_reg)
            4'd0: begin ma = $signed({7'd0, dt_reg}); mb = v_reg; madd = d_reg; end
            4'd1: begin ma = $signed({7'd0, dt_reg}); mb = p10_reg[ch_reg]; madd = p00_reg[ch_reg]; end
            4'd2: begin ma = $signed({7'd0, dt_reg}); mb = p11_reg[ch_reg]; madd = p01_reg[ch_reg]; end
            4'd3: begin ma = $signed({7'd0, dt_reg}); mb = b_reg; madd = a_reg; end
            4'd4: begin ma = $signed({7'd0, dt_reg}); mb = p11_reg[ch_reg]; madd = p10_reg[ch_reg]; end
            4'd5: begin ma = k0_reg; mb = y_reg; madd = dp_reg; end
            4'd6: begin ma = k1_reg; mb = y_reg; madd = v_reg; end
            4'd7: begin ma = g_val; mb = n00_reg; end
            4'd8: begin ma = g_val; mb = b_reg; end
            4'd9: begin ma = k1_reg; mb = n00_reg; madd = n10_reg; msub = 1'b1; end
            4'd10: begin ma = k1_reg; mb = b_reg; madd = n11_reg; msub = 1'b1; end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ma * mb;
        rnd  = (66'(prod) + (66'sd1 <<< (kf2s_pkg::FRACTION_BITS - 1)))
               >>> kf2s_pkg::FRACTION_BITS;
        pc   = kf2s_pkg::clip32(rnd, mf1);
        acc  = msub ? 66'(madd) - 66'(pc)
                    : 66'(madd) + 66'(pc)
                      + ((step_reg == 4'd3) ? 66'($signed({1'b0, q_reg})) : 66'sd0);
        mres = kf2s_pkg::clip32(acc, mf2);
        if (step_reg == 4'd7 || step_reg == 4'd8)
        begin
            mres = pc;
            mf2  = 1'b0;
        end
    end

    always_comb
    begin
        g_val = kf2s_pkg::clip32(66'(kf2s_pkg::ONE_Q) - 66'(k0_reg), g_f);
        n11_q = kf2s_pkg::clip32(66'(p11_reg[ch_reg]) + 66'($signed({1'b0, q_reg})),
                                  n11_f);
        y_val = kf2s_pkg::clip32(66'(z_reg) - 66'(dp_reg), y_f);
        s_val = 34'(n00_reg) + 34'($signed({1'b0, r_reg}));
    end

    assign div_num = (state_reg == S_DIV0) ? n00_reg : n10_reg;
    // No division is started when the innovation variance is not positive.
    assign div_start = (state_reg == S_DIV0 && s_val > 0) || state_reg == S_DIV1;

    kf2s_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(34'(s_val)), .done(div_done), .quot(div_q), .sat(div_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            dt_reg    <= kf2s_pkg::DT_RESET;
            q_reg     <= kf2s_pkg::Q_RESET;
            r_reg     <= kf2s_pkg::R_RESET;
            for (int i = 0; i < NCH; i++)
            begin
                sd_reg[i] <= '0; sv_reg[i] <= '0;
                p00_reg[i] <= kf2s_pkg::ONE_Q; p01_reg[i] <= '0;
                p10_reg[i] <= '0; p11_reg[i] <= kf2s_pkg::ONE_Q;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        unique case (cfg_index)
                            kf2s_pkg::REG_DT: dt_reg <= cfg_data;
                            kf2s_pkg::REG_Q:  q_reg  <= cfg_data;
                            kf2s_pkg::REG_R:  r_reg  <= cfg_data;
                            default: ;
                        endcase
                    end
                    if (in_valid)
                    begin
                        state_reg <= (32'(channel) >= NCH) ? S_OUT : S_MUL;
                        step_reg  <= '0;
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd4)
                        state_reg <= S_DIV0;
                    if (step_reg == 4'd10)
                    begin
                        state_reg <= S_OUT;
                        if (!skip_reg)
                        begin
                            sd_reg[ch_reg] <= d_reg;  sv_reg[ch_reg] <= v_reg;
                            p00_reg[ch_reg] <= o00_reg; p01_reg[ch_reg] <= o01_reg;
                            p10_reg[ch_reg] <= o10_reg; p11_reg[ch_reg] <= mres;
                        end
                    end
                end
                S_DIV0: state_reg <= (s_val > 0) ? S_WAIT0 : S_MUL;
                S_WAIT0: if (div_done) state_reg <= S_DIV1;
                S_DIV1: state_reg <= S_WAIT1;
                S_WAIT1: if (div_done) state_reg <= S_MUL;
                S_OUT: if (!out_stall) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            ch_reg   <= kf2s_pkg::CH_W'(channel);
            skip_reg <= 32'(channel) >= NCH;
            z_reg    <= measurement;
            d_reg    <= (32'(channel) >= NCH) ? '0 : sd_reg[kf2s_pkg::CH_W'(channel)];
            v_reg    <= (32'(channel) >= NCH) ? '0 : sv_reg[kf2s_pkg::CH_W'(channel)];
            sat_reg  <= 1'b0;
        end
        if (state_reg == S_MUL)
        begin
            sat_reg <= sat_reg | mf1 | mf2 | ((step_reg == 4'd7) & g_f)
                       | ((step_reg == 4'd4) & (n11_f | y_f));
            unique case (step_reg)
                4'd0: dp_reg <= mres;
                4'd1: a_reg  <= mres;
                4'd2: b_reg  <= mres;
                4'd3: n00_reg <= mres;
                4'd4:
                begin
                    n10_reg <= mres; n11_reg <= n11_q; y_reg <= y_val;
                    k0_reg <= '0; k1_reg <= '0;
                end
                4'd5: d_reg <= mres;
                4'd6: v_reg <= mres;
                4'd7: o00_reg <= mres;
                4'd8: o01_reg <= mres;
                4'd9: o10_reg <= mres;
                default: ;
            endcase
        end
        if (div_done && state_reg == S_WAIT0)
        begin
            k0_reg <= div_q; sat_reg <= sat_reg | div_sat;
        end
        if (div_done && state_reg == S_WAIT1)
        begin
            k1_reg <= div_q; sat_reg <= sat_reg | div_sat;
        end
    end

    assign distance_estimate = d_reg;
    assign velocity_estimate = v_reg;
    assign saturated         = sat_reg;

    `KF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")
    `KF_ASSERT(a_busy_stall, clk, rst_n, out_valid |-> in_stall, "ready with result pending")
    `KF_ASSERT(a_cfg_idle, clk, rst_n, cfg_ready |-> !out_valid, "cfg ready while busy")
endmodule
`default_nettype wire

FILE: rtl/core/kf2s_divider.sv
`default_nettype none
`include "kalman_filter_two_state_defines.svh"
// Restoring divider, one quotient bit per cycle, rounding half away from zero.
module kf2s_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic [33:0]        den,
    output logic                    done,
    output logic signed [31:0]      quot,
    output logic                    sat
);
    localparam int NB = kf2s_pkg::DIV_BITS;
    localparam int CW = $clog2(NB + 1);
    logic [NB-1:0] dvd_reg, dvd_next;
    logic [34:0]   rem_reg, rem_next;
    logic [33:0]   den_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [34:0]   trial;
    logic [NB:0]   qmag;
    logic signed [65:0] sq;

    always_comb
    begin
        trial    = {rem_reg[33:0], dvd_reg[NB-1]};
        dvd_next = {dvd_reg[NB-2:0], 1'b0};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next    = trial - {1'b0, den_reg};
            dvd_next[0] = 1'b1;
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // Dividend is (|n| << F) + s/2; quotient bits shift in at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= (NB'({1'b0, (num < 0) ? 32'(-num) : 32'(num)})
                        << kf2s_pkg::FRACTION_BITS) + NB'(den >> 1);
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num < 0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        qmag = {1'b0, dvd_reg};
        sq   = neg_reg ? -66'($signed({1'b0, qmag})) : 66'($signed({1'b0, qmag}));
        quot = kf2s_pkg::clip32(sq, sat);
    end

    `KF_ASSERT(a_div_start_idle, clk, rst_n, start |-> !busy_reg, "divider restarted")
    `KF_ASSERT(a_div_done_pulse, clk, rst_n, done |=> !done, "done held")
    `KF_ASSERT(a_div_done_end, clk, rst_n, done |-> !busy_reg, "done while busy")
endmodule
`default_nettype wire
